@@ hdl/lpms_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lift platform motor sequencer package
// Shared state, command, mode and event codes, register indexes and reset
// values.
// ----------------------------------------------------------------------------
package lpms_pkg;

	// Internal sequencer state, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DOWN = 4'b0010,
		ST_UP   = 4'b0100,
		ST_DEAD = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_UP   = 2'd1,
		CMD_DOWN = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	// Mode codes as reported on the result word.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_DOWN = 2'd1;
	localparam logic [1:0] MODE_UP   = 2'd2;
	localparam logic [1:0] MODE_DEAD = 2'd3;

	// Event codes.
	localparam logic [3:0] EV_NONE    = 4'd0;
	localparam logic [3:0] EV_BOTTOM  = 4'd1;
	localparam logic [3:0] EV_TOP     = 4'd2;
	localparam logic [3:0] EV_CANCEL  = 4'd3;
	localparam logic [3:0] EV_LOWER   = 4'd4;
	localparam logic [3:0] EV_TARGET  = 4'd5;
	localparam logic [3:0] EV_TIMEOUT = 4'd6;
	localparam logic [3:0] EV_UP_ON   = 4'd7;
	localparam logic [3:0] EV_DOWN_ON = 4'd8;
	localparam logic [3:0] EV_REVERSE = 4'd9;

	// Motor line patterns: bit 0 drives up, bit 1 drives down.
	localparam logic [1:0] MOTOR_OFF  = 2'b00;
	localparam logic [1:0] MOTOR_UP   = 2'b01;
	localparam logic [1:0] MOTOR_DOWN = 2'b10;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MOVE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd5;

	// Configuration reset values.
	localparam logic [15:0] REFERENCE_RST = 16'd0;
	localparam logic [31:0] CHECK_RST     = 32'd10000;
	localparam logic [31:0] MAX_MOVE_RST  = 32'd30000;
	localparam logic [15:0] DEAD_TIME_RST = 16'd1000;
	localparam logic [15:0] STEP_RST      = 16'd50;

	function automatic logic [1:0] mode_code(input state_t s);
		logic [1:0] m;
		m = MODE_IDLE;
		unique case (s)
			ST_IDLE: m = MODE_IDLE;
			ST_DOWN: m = MODE_DOWN;
			ST_UP:   m = MODE_UP;
			ST_DEAD: m = MODE_DEAD;
			default: m = MODE_IDLE;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

@@ hdl/lpms_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lift platform motor sequencer channels
// Command word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface lpms_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] now_ms;
	logic        top_limit;
	logic        bottom_limit;
	logic        sensor_present;
	logic [15:0] min_distance_mm;
	logic [15:0] max_distance_mm;

	modport source (output valid, command, now_ms, top_limit, bottom_limit,
		sensor_present, min_distance_mm, max_distance_mm, input ready);
	modport sink (input valid, command, now_ms, top_limit, bottom_limit,
		sensor_present, min_distance_mm, max_distance_mm, output ready);
endinterface

interface lpms_res_if;
	logic       valid;
	logic       ready;
	logic       motor_up;
	logic       motor_down;
	logic [1:0] mode;
	logic [3:0] event_res;

	modport source (output valid, motor_up, motor_down, mode, event_res,
		input ready);
	modport sink (input valid, motor_up, motor_down, mode, event_res,
		output ready);
endinterface

interface lpms_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/lift_platform_motor_sequencer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lift platform motor sequencer
// Four-state up/down motor controller with limit switches, reversal dead
// time and automatic sensor-driven lowering.
// ----------------------------------------------------------------------------
// Every command word produces exactly one result word. A word is captured in
// an input register. The next state and the result are formed combinationally
// and loaded into the result register, so the unit takes one word per clock
// while its result register is free or being taken. A result word is presented
// from the result register after its word has passed the input register. The
// rate is set by the single state update per word. While a result waits, one
// more word can enter the input register; after that the input stalls until the
// result is taken. Configuration writes are always taken and apply at once.
module lift_platform_motor_sequencer_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpms_cmd_if.sink   item,
	lpms_res_if.source result,
	lpms_cfg_if.sink   cfg
);

	// Configuration registers.
	logic [15:0] reference_q;
	logic        manual_q;
	logic [31:0] check_q;
	logic [31:0] max_move_q;
	logic [15:0] dead_time_q;
	logic [15:0] step_q;

	// Sequencer state.
	lpms_pkg::state_t state_q, state_d;
	lpms_pkg::state_t pend_q, pend_d;
	logic [31:0] dead_start_q, dead_start_d;
	logic [15:0] target_q, target_d;
	logic [31:0] move_start_q, move_start_d;
	logic [31:0] last_check_q, last_check_d;
	logic [1:0]  motor_q, motor_d;
	logic [3:0]  ev_d;

	// Input register.
	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [31:0] now_s1;
	logic        top_s1;
	logic        bottom_s1;
	logic        present_s1;
	logic [15:0] dmin_s1;
	logic [15:0] dmax_s1;

	// Result register.
	logic        out_valid_q;
	logic        out_up_q;
	logic        out_down_q;
	logic [1:0]  out_mode_q;
	logic [3:0]  out_event_q;

	logic        advance;
	logic        take_in;
	logic [31:0] since_check;
	logic [31:0] since_move;
	logic [31:0] since_dead;
	logic [16:0] target_sum;
	logic [15:0] target_sat;
	logic        reading_ok;

	assign advance  = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take_in  = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q <= lpms_pkg::REFERENCE_RST;
			manual_q    <= 1'b0;
			check_q     <= lpms_pkg::CHECK_RST;
			max_move_q  <= lpms_pkg::MAX_MOVE_RST;
			dead_time_q <= lpms_pkg::DEAD_TIME_RST;
			step_q      <= lpms_pkg::STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lpms_pkg::REG_REFERENCE: reference_q <= cfg.data[15:0];
				lpms_pkg::REG_MANUAL:    manual_q    <= cfg.data[0];
				lpms_pkg::REG_CHECK:     check_q     <= cfg.data;
				lpms_pkg::REG_MAX_MOVE:  max_move_q  <= cfg.data;
				lpms_pkg::REG_DEAD_TIME: dead_time_q <= cfg.data[15:0];
				lpms_pkg::REG_STEP:      step_q      <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			command_s1 <= item.command;
			now_s1     <= item.now_ms;
			top_s1     <= item.top_limit;
			bottom_s1  <= item.bottom_limit;
			present_s1 <= item.sensor_present;
			dmin_s1    <= item.min_distance_mm;
			dmax_s1    <= item.max_distance_mm;
		end
	end

	assign since_check = now_s1 - last_check_q;
	assign since_move  = now_s1 - move_start_q;
	assign since_dead  = now_s1 - dead_start_q;
	assign target_sum  = {1'b0, dmin_s1} + {1'b0, step_q};
	assign target_sat  = target_sum[16] ? 16'hFFFF : target_sum[15:0];
	assign reading_ok  = present_s1 && (dmin_s1 != 16'd0);

	always_comb begin
		state_d      = state_q;
		pend_d       = pend_q;
		dead_start_d = dead_start_q;
		target_d     = target_q;
		move_start_d = move_start_q;
		last_check_d = last_check_q;
		motor_d      = motor_q;
		ev_d         = lpms_pkg::EV_NONE;

		unique case (lpms_pkg::cmd_t'(command_s1))
			lpms_pkg::CMD_TICK: begin
				// Limit switches act before the per-state work.
				if (bottom_s1 && state_d == lpms_pkg::ST_DOWN) begin
					motor_d = lpms_pkg::MOTOR_OFF;
					state_d = lpms_pkg::ST_IDLE;
					ev_d    = lpms_pkg::EV_BOTTOM;
				end else if (top_s1 && state_d == lpms_pkg::ST_UP) begin
					motor_d = lpms_pkg::MOTOR_OFF;
					state_d = lpms_pkg::ST_IDLE;
					ev_d    = lpms_pkg::EV_TOP;
				end else if ((bottom_s1 || top_s1) && state_d == lpms_pkg::ST_DEAD) begin
					state_d = lpms_pkg::ST_IDLE;
					ev_d    = lpms_pkg::EV_CANCEL;
				end

				unique case (state_d)
					lpms_pkg::ST_IDLE: begin
						if (!manual_q && since_check >= check_q) begin
							last_check_d = now_s1;
							if (present_s1 && dmax_s1 < reference_q) begin
								target_d     = target_sat;
								move_start_d = now_s1;
								ev_d         = lpms_pkg::EV_LOWER;
								// The bottom limit still blocks the motor itself.
								if (!bottom_s1) begin
									motor_d = lpms_pkg::MOTOR_DOWN;
									state_d = lpms_pkg::ST_DOWN;
								end
							end
						end
					end
					lpms_pkg::ST_DOWN: begin
						if (!manual_q) begin
							if (reading_ok && dmin_s1 >= target_q) begin
								motor_d = lpms_pkg::MOTOR_OFF;
								state_d = lpms_pkg::ST_IDLE;
								ev_d    = lpms_pkg::EV_TARGET;
							end else if (since_move >= max_move_q) begin
								motor_d = lpms_pkg::MOTOR_OFF;
								state_d = lpms_pkg::ST_IDLE;
								ev_d    = lpms_pkg::EV_TIMEOUT;
							end
						end
					end
					lpms_pkg::ST_UP: begin
					end
					lpms_pkg::ST_DEAD: begin
						if (since_dead >= {16'd0, dead_time_q}) begin
							if (pend_q == lpms_pkg::ST_UP) begin
								motor_d = lpms_pkg::MOTOR_UP;
								state_d = lpms_pkg::ST_UP;
								ev_d    = lpms_pkg::EV_UP_ON;
							end else if (pend_q == lpms_pkg::ST_DOWN) begin
								motor_d = lpms_pkg::MOTOR_DOWN;
								state_d = lpms_pkg::ST_DOWN;
								ev_d    = lpms_pkg::EV_DOWN_ON;
							end else begin
								state_d = lpms_pkg::ST_IDLE;
							end
						end
					end
					default: state_d = lpms_pkg::ST_IDLE;
				endcase
			end
			lpms_pkg::CMD_UP: begin
				if (!top_s1) begin
					if (state_q == lpms_pkg::ST_DOWN) begin
						motor_d      = lpms_pkg::MOTOR_OFF;
						pend_d       = lpms_pkg::ST_UP;
						dead_start_d = now_s1;
						state_d      = lpms_pkg::ST_DEAD;
						ev_d         = lpms_pkg::EV_REVERSE;
					end else if (state_q != lpms_pkg::ST_DEAD) begin
						motor_d = lpms_pkg::MOTOR_UP;
						state_d = lpms_pkg::ST_UP;
					end
				end
			end
			lpms_pkg::CMD_DOWN: begin
				if (!bottom_s1) begin
					if (state_q == lpms_pkg::ST_UP) begin
						motor_d      = lpms_pkg::MOTOR_OFF;
						pend_d       = lpms_pkg::ST_DOWN;
						dead_start_d = now_s1;
						state_d      = lpms_pkg::ST_DEAD;
						ev_d         = lpms_pkg::EV_REVERSE;
					end else if (state_q != lpms_pkg::ST_DEAD) begin
						motor_d = lpms_pkg::MOTOR_DOWN;
						state_d = lpms_pkg::ST_DOWN;
					end
				end
			end
			lpms_pkg::CMD_STOP: begin
				motor_d = lpms_pkg::MOTOR_OFF;
				state_d = lpms_pkg::ST_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lpms_pkg::ST_IDLE;
			pend_q       <= lpms_pkg::ST_IDLE;
			dead_start_q <= '0;
			target_q     <= '0;
			move_start_q <= '0;
			last_check_q <= '0;
			motor_q      <= lpms_pkg::MOTOR_OFF;
		end else if (advance) begin
			state_q      <= state_d;
			pend_q       <= pend_d;
			dead_start_q <= dead_start_d;
			target_q     <= target_d;
			move_start_q <= move_start_d;
			last_check_q <= last_check_d;
			motor_q      <= motor_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_up_q    <= motor_d[0];
			out_down_q  <= motor_d[1];
			out_mode_q  <= lpms_pkg::mode_code(state_d);
			out_event_q <= ev_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.motor_up   = out_up_q;
	assign result.motor_down = out_down_q;
	assign result.mode       = out_mode_q;
	assign result.event_res  = out_event_q;

	// The motor is never driven both ways at once.
	a_motor_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(motor_q[0] && motor_q[1]))
		else $error("motor lines driven in both directions");

	// Both motor lines are off throughout the reversal wait.
	a_dead_motor_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpms_pkg::ST_DEAD) |-> (motor_q == lpms_pkg::MOTOR_OFF))
		else $error("motor driven during dead time");

	// Sequencer state moves only when a word is processed.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q) && $stable(motor_q))
		else $error("state changed without a word");

	// A reported upward drive always comes with the moving-up mode.
	a_result_up_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_up_q) |-> (out_mode_q == lpms_pkg::MODE_UP))
		else $error("upward drive reported outside moving-up mode");

endmodule
`default_nettype wire
